@@ hdl/adb_pkg.sv @@
// shared types, constants and table functions of the block decoder
package adb_pkg;

    localparam int MAX_BLOCK_BYTES_DEF = 4096;
    localparam int QUEUE_DEPTH         = 4;
    localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);

    localparam logic [12:0] BLOCK_BYTES_RST = 13'd256;
    localparam logic [3:0]  HDR_MONO        = 4'd7;
    localparam logic [3:0]  HDR_STEREO      = 4'd14;

    localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;
    localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;
    localparam logic signed [23:0] STEP_MIN   = 24'sd16;
    localparam logic signed [23:0] STEP_MAX   = 24'sd8388607;

    localparam logic CFG_BLOCK_BYTES = 1'b0;
    localparam logic CFG_STEREO      = 1'b1;

    typedef enum logic [2:0] {
        OP_PRED,
        OP_STEP,
        OP_S1,
        OP_S2,
        OP_DATA
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic        ch;
        logic [15:0] value;
        logic        stereo;
        logic        seeds;
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEED,
        BK_MUL,
        BK_ACC
    } back_state_t;

    // byte mod 7 by folding octal digits, since 8 is 1 mod 7
    function automatic logic [2:0] mod7(input logic [7:0] b);
        logic [4:0] f1;
        logic [3:0] f2;
        f1 = 5'(b[2:0]) + 5'(b[5:3]) + 5'(b[7:6]);
        f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
        return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    endfunction

    function automatic logic signed [10:0] coef_a(input logic [2:0] pi);
        logic signed [10:0] c;
        case (pi)
            3'd0: c = 11'sd256;
            3'd1: c = 11'sd512;
            3'd2: c = 11'sd0;
            3'd3: c = 11'sd192;
            3'd4: c = 11'sd240;
            3'd5: c = 11'sd460;
            3'd6: c = 11'sd392;
            default: c = 11'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [10:0] coef_b(input logic [2:0] pi);
        logic signed [10:0] c;
        case (pi)
            3'd0: c = 11'sd0;
            3'd1: c = -11'sd256;
            3'd2: c = 11'sd0;
            3'd3: c = 11'sd64;
            3'd4: c = 11'sd0;
            3'd5: c = -11'sd208;
            3'd6: c = -11'sd232;
            default: c = 11'sd0;
        endcase
        return c;
    endfunction

    function automatic logic [9:0] adapt(input logic [3:0] nb);
        logic [9:0] a;
        case (nb)
            4'd0, 4'd1, 4'd2, 4'd3:    a = 10'd230;
            4'd4:                      a = 10'd307;
            4'd5:                      a = 10'd409;
            4'd6:                      a = 10'd512;
            4'd7:                      a = 10'd614;
            4'd8:                      a = 10'd768;
            4'd9:                      a = 10'd614;
            4'd10:                     a = 10'd512;
            4'd11:                     a = 10'd409;
            4'd12:                     a = 10'd307;
            default:                   a = 10'd230;
        endcase
        return a;
    endfunction

endpackage

@@ hdl/adb_front.sv @@
// front end: configuration, block position tracking and byte classification
module adb_front #(
    parameter int MAX_BLOCK_BYTES = adb_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // data_byte
    input  logic           s_tlast,   // end_of_buffer
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [12:0]    cfg_data,
    output logic           op_valid,
    input  logic           op_ready,
    output adb_pkg::op_t   op
);

    localparam int POS_W = $clog2(MAX_BLOCK_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       pend_reg, pend_next;
    logic [12:0]      block_bytes_reg, block_bytes_next;
    logic             stereo_reg, stereo_next;

    logic [1:0] nch;
    logic [3:0] hdr;
    logic [3:0] q;
    logic [1:0] field;
    logic       bad;
    logic       emit;
    logic       accept;

    assign s_tready  = op_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign op_valid  = s_tvalid && emit;

    always_comb begin
        nch   = stereo_reg ? 2'd2 : 2'd1;
        hdr   = stereo_reg ? adb_pkg::HDR_STEREO : adb_pkg::HDR_MONO;
        bad   = (block_bytes_reg < 13'(hdr)) ||
                (32'(block_bytes_reg) > 32'(MAX_BLOCK_BYTES));
        q     = pos_reg[3:0] - 4'(nch);
        field = stereo_reg ? q[3:2] : q[2:1];
        emit  = 1'b0;
        pend_next = pend_reg;

        op.kind   = adb_pkg::OP_DATA;
        op.ch     = 1'b0;
        op.value  = {8'd0, s_tdata};
        op.stereo = stereo_reg;
        op.seeds  = 1'b0;

        if (!bad) begin
            if (32'(pos_reg) < 32'(nch)) begin
                emit     = 1'b1;
                op.kind  = adb_pkg::OP_PRED;
                op.ch    = pos_reg[0];
                op.value = {13'd0, adb_pkg::mod7(s_tdata)};
            end else if (32'(pos_reg) < 32'(hdr)) begin
                if (q[0]) begin
                    emit     = 1'b1;
                    op.ch    = stereo_reg ? q[1] : 1'b0;
                    op.value = {s_tdata, pend_reg};
                    op.seeds = (32'(pos_reg) == 32'(hdr) - 32'd1);
                    case (field)
                        2'd0:    op.kind = adb_pkg::OP_STEP;
                        2'd1:    op.kind = adb_pkg::OP_S1;
                        default: op.kind = adb_pkg::OP_S2;
                    endcase
                end else if (accept) begin
                    pend_next = s_tdata;
                end
            end else begin
                emit = 1'b1;
            end
        end

        pos_next = pos_reg;
        if (accept) begin
            if (bad || s_tlast || (32'(pos_reg) + 32'd1 >= 32'(block_bytes_reg))) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end

        block_bytes_next = block_bytes_reg;
        stereo_next      = stereo_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                adb_pkg::CFG_BLOCK_BYTES: block_bytes_next = cfg_data;
                adb_pkg::CFG_STEREO:      stereo_next      = cfg_data[0];
                default:                  block_bytes_next = block_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            pend_reg        <= '0;
            block_bytes_reg <= adb_pkg::BLOCK_BYTES_RST;
            stereo_reg      <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            pend_reg        <= pend_next;
            block_bytes_reg <= block_bytes_next;
            stereo_reg      <= stereo_next;
        end
    end

endmodule

@@ hdl/adb_fifo.sv @@
// short operation queue between front end and back end
module adb_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  adb_pkg::op_t  in_op,
    output logic          out_valid,
    input  logic          out_ready,
    output adb_pkg::op_t  out_op
);

    adb_pkg::op_t mem_reg [adb_pkg::QUEUE_DEPTH];

    logic [adb_pkg::QUEUE_AW-1:0] wr_reg, wr_next;
    logic [adb_pkg::QUEUE_AW-1:0] rd_reg, rd_next;
    logic [adb_pkg::QUEUE_AW:0]   cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready  = (32'(cnt_reg) < adb_pkg::QUEUE_DEPTH);
    assign out_valid = (cnt_reg != '0);
    assign out_op    = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hdl/adb_back.sv @@
// back end: channel state, seed output and two-stage nibble decode
module adb_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          op_valid,
    output logic          op_ready,
    input  adb_pkg::op_t  op,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,   // sample
    output logic          m_tuser,   // channel
    output logic          m_tlast    // last_of_run
);

    adb_pkg::back_state_t state_reg, state_next;

    adb_pkg::op_t cur_reg, cur_next;
    logic         nib_reg, nib_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         ch_reg, ch_next;

    logic [2:0]        pred_reg [2], pred_next [2];
    logic signed [23:0] step_reg [2], step_next [2];
    logic signed [15:0] s1_reg [2], s1_next [2];
    logic signed [15:0] s2_reg [2], s2_next [2];

    logic signed [26:0] pa_reg, pa_next;
    logic signed [26:0] pb_reg, pb_next;
    logic signed [28:0] pd_reg, pd_next;
    logic signed [34:0] ps_reg, ps_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic        out_user_reg, out_user_next;
    logic        out_last_reg, out_last_next;

    logic              out_free;
    logic              mul_ch;
    logic [3:0]        mul_nb;
    logic signed [4:0] mul_sn;
    logic              seed_ch;
    logic              seed_last;
    logic              seed_old;
    logic signed [27:0] pred_sum;
    logic signed [19:0] pred;
    logic signed [29:0] tot;
    logic signed [15:0] smp;
    logic signed [26:0] st_raw;
    logic signed [23:0] st_new;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign op_ready = (state_reg == adb_pkg::BK_IDLE);

    always_comb begin
        mul_ch = nib_reg ? cur_reg.stereo : 1'b0;
        mul_nb = nib_reg ? cur_reg.value[3:0] : cur_reg.value[7:4];
        mul_sn = {mul_nb[3], mul_nb};

        seed_ch   = cur_reg.stereo ? cnt_reg[0] : 1'b0;
        seed_old  = cur_reg.stereo ? !cnt_reg[1] : (cnt_reg == 2'd0);
        seed_last = cur_reg.stereo ? (cnt_reg == 2'd3) : (cnt_reg == 2'd1);

        // floor division by 256 is an arithmetic shift
        pred_sum = pa_reg + pb_reg;
        pred     = pred_sum[27:8];
        tot      = pred + pd_reg;
        if (tot < 30'(adb_pkg::SAMPLE_MIN)) begin
            smp = adb_pkg::SAMPLE_MIN;
        end else if (tot > 30'(adb_pkg::SAMPLE_MAX)) begin
            smp = adb_pkg::SAMPLE_MAX;
        end else begin
            smp = tot[15:0];
        end
        st_raw = ps_reg[34:8];
        if (st_raw < 27'(adb_pkg::STEP_MIN)) begin
            st_new = adb_pkg::STEP_MIN;
        end else if (st_raw > 27'(adb_pkg::STEP_MAX)) begin
            st_new = adb_pkg::STEP_MAX;
        end else begin
            st_new = st_raw[23:0];
        end

        state_next = state_reg;
        cur_next   = cur_reg;
        nib_next   = nib_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        pred_next  = pred_reg;
        step_next  = step_reg;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        pd_next    = pd_reg;
        ps_next    = ps_reg;

        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            adb_pkg::BK_IDLE: begin
                if (op_valid) begin
                    cur_next = op;
                    case (op.kind)
                        adb_pkg::OP_PRED: pred_next[op.ch] = op.value[2:0];
                        adb_pkg::OP_STEP: step_next[op.ch] = 24'($signed(op.value));
                        adb_pkg::OP_S1:   s1_next[op.ch]   = $signed(op.value);
                        adb_pkg::OP_S2: begin
                            s2_next[op.ch] = $signed(op.value);
                            if (op.seeds) begin
                                cnt_next   = 2'd0;
                                state_next = adb_pkg::BK_SEED;
                            end
                        end
                        adb_pkg::OP_DATA: begin
                            nib_next   = 1'b0;
                            state_next = adb_pkg::BK_MUL;
                        end
                        default: state_next = adb_pkg::BK_IDLE;
                    endcase
                end
            end
            adb_pkg::BK_SEED: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = seed_old ? s2_reg[seed_ch] : s1_reg[seed_ch];
                    out_user_next  = seed_ch;
                    out_last_next  = seed_last;
                    cnt_next       = cnt_reg + 2'd1;
                    if (seed_last) begin
                        state_next = adb_pkg::BK_IDLE;
                    end
                end
            end
            adb_pkg::BK_MUL: begin
                ch_next    = mul_ch;
                pa_next    = s1_reg[mul_ch] * adb_pkg::coef_a(pred_reg[mul_ch]);
                pb_next    = s2_reg[mul_ch] * adb_pkg::coef_b(pred_reg[mul_ch]);
                pd_next    = step_reg[mul_ch] * mul_sn;
                ps_next    = step_reg[mul_ch] * $signed({1'b0, adb_pkg::adapt(mul_nb)});
                state_next = adb_pkg::BK_ACC;
            end
            adb_pkg::BK_ACC: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = smp;
                    out_user_next   = ch_reg;
                    out_last_next   = nib_reg;
                    s2_next[ch_reg]   = s1_reg[ch_reg];
                    s1_next[ch_reg]   = smp;
                    step_next[ch_reg] = st_new;
                    if (nib_reg) begin
                        state_next = adb_pkg::BK_IDLE;
                    end else begin
                        nib_next   = 1'b1;
                        state_next = adb_pkg::BK_MUL;
                    end
                end
            end
            default: state_next = adb_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= adb_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nib_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            pred_reg      <= '{default: '0};
            step_reg      <= '{default: '0};
            s1_reg        <= '{default: '0};
            s2_reg        <= '{default: '0};
        end else begin
            nib_reg       <= nib_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            pred_reg      <= pred_next;
            step_reg      <= step_next;
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        ch_reg       <= ch_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        pd_reg       <= pd_next;
        ps_reg       <= ps_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    a_pred_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pred_reg[0] <= 3'd6) && (pred_reg[1] <= 3'd6))
        else $error("predictor index out of range");

    a_acc_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == adb_pkg::BK_ACC && out_free) |=> out_valid_reg)
        else $error("decoded sample not presented");

    a_acc_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == adb_pkg::BK_ACC && out_free && nib_reg)
        |=> (state_reg == adb_pkg::BK_IDLE && out_last_reg))
        else $error("data byte did not finish with a last sample");

    a_seed_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == adb_pkg::BK_IDLE && op_valid && op.kind == adb_pkg::OP_S2 && op.seeds)
        |=> (state_reg == adb_pkg::BK_SEED && cnt_reg == 2'd0))
        else $error("seed output not started on last header byte");

endmodule

@@ hdl/ms_adpcm_block_decoder.sv @@
// top level of the block adpcm decoder: front end, operation queue, back end
//
//  channel   ports            tdata / data             tuser      tlast
//  input     s_tvalid/tready  [7:0] data_byte          -          end_of_buffer
//  result    m_tvalid/tready  [15:0] sample            channel    last_of_run
//  config    cfg_valid/ready  cfg_data [12:0] value    -          cfg_index selects
//
// header bytes are taken by the front end; bytes that complete a field also pass an
// operation on, and the last header byte then adds 2 (mono) or 4 (stereo) seed samples
// a data byte passes these back-end steps: a queue read, then two nibble decodes of a
// multiply stage and an accumulate and clamp stage each, on one set of multipliers
// reset restores the default configuration, clears block position and all channel state
// a 4-entry operation queue lets input continue while results stall, until it is full
module ms_adpcm_block_decoder #(
    parameter int MAX_BLOCK_BYTES = adb_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample
    output logic        m_tuser,   // channel
    output logic        m_tlast,   // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    logic         fq_valid, fq_ready;
    adb_pkg::op_t fq_op;
    logic         qb_valid, qb_ready;
    adb_pkg::op_t qb_op;

    adb_front #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_valid  (fq_valid),
        .op_ready  (fq_ready),
        .op        (fq_op)
    );

    adb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_op     (fq_op),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_op    (qb_op)
    );

    adb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (qb_valid),
        .op_ready (qb_ready),
        .op       (qb_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ test/adpcm_decode_checker.sv @@
// checker for the block adpcm decoder: predicts the samples of every byte transfer and compares
module adpcm_decode_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_buffer
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // sample
    input  logic        m_tuser,   // channel
    input  logic        m_tlast,   // last_of_run
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    output int          sample_errors,
    output int          samples_waiting,
    output int          samples_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EXP_DEPTH = 64;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               channel;
        logic               last;
    } pcm_t;

    int adapt_scale [16] = '{230, 230, 230, 230, 307, 409, 512, 614,
                             768, 614, 512, 409, 307, 230, 230, 230};
    int coef_s1 [7] = '{256, 512, 0, 192, 240, 460, 392};
    int coef_s2 [7] = '{0, -256, 0, 64, 0, -208, -232};

    logic [12:0]        block_bytes_cfg;
    logic               stereo_cfg;
    logic [11:0]        byte_pos;
    logic [2:0]         coef_sel [2];
    logic signed [23:0] step [2];
    logic signed [15:0] s1_hist [2];
    logic signed [15:0] s2_hist [2];
    logic [7:0]         low_byte;
    pcm_t               expect_buf [EXP_DEPTH];
    logic [5:0]         exp_head;
    logic [5:0]         exp_tail;
    int                 exp_fill;
    int                 errs;

    task automatic stash_sample(input pcm_t s);
        if (exp_fill == EXP_DEPTH) begin
            $display("%0t: expected-sample buffer overflow", $time);
            errs++;
        end else begin
            expect_buf[exp_tail] = s;
            exp_tail = exp_tail + 6'd1;
            exp_fill++;
        end
    endtask

    function automatic logic signed [15:0] adpcm_nibble(input int ch, input logic [3:0] nib);
        longint pred;
        longint acc;
        longint st;
        pred = (longint'(s1_hist[ch]) * coef_s1[coef_sel[ch]]
                + longint'(s2_hist[ch]) * coef_s2[coef_sel[ch]]) >>> 8;
        acc = pred + longint'($signed(nib)) * longint'(step[ch]);
        if (acc < -32768) begin
            acc = -32768;
        end else if (acc > 32767) begin
            acc = 32767;
        end
        s2_hist[ch] = s1_hist[ch];
        s1_hist[ch] = 16'(acc);
        st = (longint'(adapt_scale[nib]) * longint'(step[ch])) >>> 8;
        if (st < 16) begin
            st = 16;
        end else if (st > 8388607) begin
            st = 8388607;
        end
        step[ch] = 24'(st);
        return 16'(acc);
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic eob);
        int nch;
        int hdr;
        int p;
        int q;
        int field;
        int slot;
        int c;
        logic [15:0] raw;
        logic signed [15:0] hi;
        logic signed [15:0] lo;
        nch = stereo_cfg ? 2 : 1;
        hdr = 7 * nch;
        p = byte_pos;
        if (block_bytes_cfg < hdr || block_bytes_cfg > adb_pkg::MAX_BLOCK_BYTES_DEF) begin
            byte_pos = '0;
        end else begin
            if (p < nch) begin
                coef_sel[p] = 3'(b % 8'd7);
            end else if (p < hdr) begin
                q = p - nch;
                field = q / (2 * nch);
                slot = q % (2 * nch);
                c = (slot >> 1) & 1;
                if (slot % 2 == 0) begin
                    low_byte = b;
                end else begin
                    raw = {b, low_byte};
                    case (field)
                        0: step[c] = {{8{raw[15]}}, raw};
                        1: s1_hist[c] = raw;
                        default: s2_hist[c] = raw;
                    endcase
                end
                // seeds: s2 of each channel, then s1 of each channel
                if (p == hdr - 1) begin
                    for (int k = 0; k < 2 * nch; k++) begin
                        c = k % nch;
                        stash_sample(pcm_t'{
                            sample: (k < nch) ? s2_hist[c] : s1_hist[c],
                            channel: c[0],
                            last: (k == 2 * nch - 1)});
                    end
                end
            end else begin
                hi = adpcm_nibble(0, b[7:4]);
                stash_sample(pcm_t'{sample: hi, channel: 1'b0, last: 1'b0});
                lo = adpcm_nibble(stereo_cfg ? 1 : 0, b[3:0]);
                stash_sample(pcm_t'{sample: lo, channel: stereo_cfg, last: 1'b1});
            end
            if (eob || p + 1 >= block_bytes_cfg) begin
                byte_pos = '0;
            end else begin
                byte_pos = 12'(p + 1);
            end
        end
    endtask

    always @(posedge aclk) begin
        pcm_t want;
        errs = 0;
        if (!aresetn) begin
            block_bytes_cfg = adb_pkg::BLOCK_BYTES_RST;
            stereo_cfg = 1'b0;
            byte_pos = '0;
            low_byte = '0;
            for (int c = 0; c < 2; c++) begin
                coef_sel[c] = '0;
                step[c] = '0;
                s1_hist[c] = '0;
                s2_hist[c] = '0;
            end
            exp_head = '0;
            exp_tail = '0;
            exp_fill = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == adb_pkg::CFG_BLOCK_BYTES) begin
                    block_bytes_cfg = cfg_data;
                end else begin
                    stereo_cfg = cfg_data[0];
                end
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (exp_fill == 0) begin
                    $display("%0t: unexpected sample %0d ch %0d last %0d",
                             $time, $signed(m_tdata), m_tuser, m_tlast);
                    errs++;
                end else begin
                    want = expect_buf[exp_head];
                    exp_head = exp_head + 6'd1;
                    exp_fill--;
                    samples_seen <= samples_seen + 1;
                    if (m_tdata !== want.sample || m_tuser !== want.channel
                        || m_tlast !== want.last) begin
                        $display("%0t: expected %0d ch %0d last %0d, got %0d ch %0d last %0d",
                                 $time, $signed(want.sample), want.channel, want.last,
                                 $signed(m_tdata), m_tuser, m_tlast);
                        errs++;
                    end
                end
            end
        end
        sample_errors <= sample_errors + errs;
        samples_waiting <= exp_fill;
    end

endmodule

@@ test/tb.sv @@
// top of the block adpcm decoder testbench: clock, reset, byte and register stimulus, verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_TAIL   = 16;
    localparam int RANDOM_BYTES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [12:0] cfg_data;

    int sample_errors;
    int samples_waiting;
    int samples_seen;
    int bytes_sent;
    int cfg_writes;
    int cycle_count;
    bit tx_calm;
    bit rx_calm;
    logic        stereo_now;
    logic [12:0] block_now;

    ms_adpcm_block_decoder u_dut (.*);

    adpcm_decode_checker u_checker (.*);

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic eob);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eob;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic put_word(input logic [15:0] w);
        put_byte(w[7:0], 1'b0);
        put_byte(w[15:8], 1'b0);
    endtask

    // sender quiet until every expected sample has been taken, then for a drain tail
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (samples_waiting != 0);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == adb_pkg::CFG_STEREO) begin
            stereo_now = val[0];
        end else begin
            block_now = val;
        end
        cfg_writes++;
    endtask

    task automatic put_block(input int len, input bit eob_last);
        int nch;
        logic [7:0] b;
        nch = stereo_now ? 2 : 1;
        for (int i = 0; i < len; i++) begin
            // step high bytes often near zero so the adaptation stays off its rails
            if (i >= nch && i < 3 * nch && (i - nch) % 2 == 1 && $urandom_range(0, 1) == 1) begin
                b = ($urandom_range(0, 1) == 1) ? 8'h00 : 8'hFF;
            end else begin
                b = 8'($urandom);
            end
            put_byte(b, (eob_last && i == len - 1) || $urandom_range(0, 59) == 0);
        end
    endtask

    initial begin
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            int stall;
            stall = pick_gap(rx_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d samples still due", cycle_count, samples_waiting);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int counted;
        int hdr;
        int len;
        int nblk;
        logic [12:0] bb;
        bit size_ok;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= adb_pkg::CFG_BLOCK_BYTES;
        cfg_data <= '0;
        stereo_now = 1'b0;
        block_now = adb_pkg::BLOCK_BYTES_RST;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // mono at reset size: negative header step, extreme seeds, nibble extremes
        put_byte(8'hFF, 1'b0);
        put_word(16'h8000);
        put_word(16'h7FFF);
        put_word(16'h8000);
        put_byte(8'h0F, 1'b0);
        put_byte(8'h87, 1'b0);
        put_byte(8'h70, 1'b1);

        // stereo block of 20 bytes: the header, then one data byte
        write_reg(adb_pkg::CFG_STEREO, 13'd1);
        write_reg(adb_pkg::CFG_BLOCK_BYTES, 13'd20);
        put_byte(8'h06, 1'b0);
        put_byte(8'h07, 1'b0);
        put_word(16'h7FFF);
        put_word(16'hFFFF);
        put_word(16'h8000);
        put_word(16'h1234);
        put_word(16'h7FFF);
        put_word(16'h0000);
        put_byte(8'hF0, 1'b0);

        // switch to mono inside the block, then shrink the block below the position
        write_reg(adb_pkg::CFG_STEREO, 13'd0);
        put_byte(8'h8F, 1'b0);
        write_reg(adb_pkg::CFG_BLOCK_BYTES, 13'd7);
        put_byte(8'h3C, 1'b0);

        // size out of range gives nothing
        write_reg(adb_pkg::CFG_BLOCK_BYTES, 13'd8191);
        put_byte(8'hA5, 1'b0);
        write_reg(adb_pkg::CFG_BLOCK_BYTES, 13'd0);
        put_byte(8'h5A, 1'b1);

        counted = 0;
        while (counted < RANDOM_BYTES) begin
            write_reg(adb_pkg::CFG_STEREO, 13'($urandom_range(0, 1)));
            hdr = stereo_now ? 14 : 7;
            case ($urandom_range(0, 15))
                0: bb = 13'd7;
                1: bb = 13'd14;
                2: bb = 13'd4096;
                3: begin
                    case ($urandom_range(0, 3))
                        0: bb = 13'd0;
                        1: bb = 13'(hdr - 1);
                        2: bb = 13'd4097;
                        default: bb = 13'd8191;
                    endcase
                end
                default: bb = 13'(hdr + $urandom_range(1, 30));
            endcase
            write_reg(adb_pkg::CFG_BLOCK_BYTES, bb);
            size_ok = (bb >= hdr && bb <= adb_pkg::MAX_BLOCK_BYTES_DEF);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            nblk = $urandom_range(1, 4);
            for (int k = 0; k < nblk; k++) begin
                if (!size_ok) begin
                    put_block($urandom_range(1, 4), 1'b0);
                end else if (bb > 48) begin
                    len = hdr + $urandom_range(0, 30);
                    put_block(len, 1'b1);
                    counted += len;
                end else begin
                    put_block(bb, $urandom_range(0, 3) == 0);
                    counted += bb;
                end
                if ($urandom_range(0, 7) == 0) begin
                    settle();
                end
            end
        end

        settle();
        $display("covered %0d byte transfers, %0d samples checked, %0d register writes",
                 bytes_sent, samples_seen, cfg_writes);
        $display("mono and stereo blocks of 7 to 4096 bytes, out-of-range sizes, early ends");
        if (sample_errors == 0 && samples_waiting == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ ms_adpcm_block_decoder.f @@
hdl/adb_pkg.sv
hdl/adb_front.sv
hdl/adb_fifo.sv
hdl/adb_back.sv
hdl/ms_adpcm_block_decoder.sv
test/adpcm_decode_checker.sv
test/tb.sv
